FILE: design/jdq_pkg.sv
// shared types and constants for the packet jitter delay queue
`default_nettype none

package jdq_pkg;

    localparam int TIME_W     = 32;
    localparam int SEQ_W      = 16;
    localparam int DELAY_W    = 16;
    localparam int PORT_TAG_W = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_JITTER_EN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INBOUND_EN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OUTBOUND_EN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DELAY_LOW   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DELAY_HIGH  = 3'd4;

    localparam logic ACT_ARRIVAL = 1'b0;
    localparam logic ACT_TICK    = 1'b1;

    localparam logic [1:0] KIND_PASS    = 2'd0;
    localparam logic [1:0] KIND_DELAYED = 2'd1;
    localparam logic [1:0] KIND_FULL    = 2'd2;

    typedef struct packed {
        logic [TIME_W-1:0] rel_time;
        logic [SEQ_W-1:0]  seq;
    } order_key_t;

endpackage

`default_nettype wire

FILE: design/jdq_order.sv
// release order comparator: earliest time first, then oldest arrival
`default_nettype none

module jdq_order (
    input  jdq_pkg::order_key_t      cand,
    input  jdq_pkg::order_key_t      best,
    input  logic [jdq_pkg::SEQ_W-1:0] counter,
    output logic                     earlier
);
    import jdq_pkg::*;

    logic [SEQ_W-1:0] cand_age;
    logic [SEQ_W-1:0] best_age;

    assign cand_age = counter - cand.seq;
    assign best_age = counter - best.seq;

    always_comb
    begin
        if (cand.rel_time != best.rel_time)
        begin
            earlier = cand.rel_time < best.rel_time;
        end
        else
        begin
            earlier = cand_age > best_age;
        end
    end

endmodule

`default_nettype wire

FILE: design/jdq_delay.sv
// three-stage delay draw: span, multiply-high, offset
`default_nettype none

module jdq_delay (
    input  logic                        clk,
    input  logic [jdq_pkg::DELAY_W-1:0] delay_a,
    input  logic [jdq_pkg::DELAY_W-1:0] delay_b,
    input  logic [jdq_pkg::DELAY_W-1:0] rnd,
    output logic [jdq_pkg::DELAY_W-1:0] delay
);
    import jdq_pkg::*;

    logic [DELAY_W-1:0]     lo;
    logic [DELAY_W-1:0]     hi;
    logic [DELAY_W:0]       span_reg;
    logic [DELAY_W-1:0]     lo_reg;
    logic [DELAY_W-1:0]     lo2_reg;
    logic [DELAY_W-1:0]     rnd_reg;
    logic [2*DELAY_W:0]     prod_reg;
    logic [DELAY_W-1:0]     delay_reg;
    logic [DELAY_W:0]       delay_sum;

    assign lo = (delay_a < delay_b) ? delay_a : delay_b;
    assign hi = (delay_a < delay_b) ? delay_b : delay_a;
    assign delay_sum = {1'b0, lo2_reg} + prod_reg[2*DELAY_W:DELAY_W];

    always_ff @(posedge clk)
    begin
        span_reg  <= {1'b0, hi} - {1'b0, lo} + (DELAY_W+1)'(1);
        lo_reg    <= lo;
        rnd_reg   <= rnd;
        prod_reg  <= {{(DELAY_W+1){1'b0}}, rnd_reg} * {{DELAY_W{1'b0}}, span_reg};
        lo2_reg   <= lo_reg;
        delay_reg <= delay_sum[DELAY_W-1:0];
    end

    assign delay = delay_reg;

endmodule

`default_nettype wire

FILE: design/packet_jitter_delay_queue.sv
// top level: jitter delay queue with store, scan sequencer and config registers
//
// Usage: drive an item on action, packet_tag, is_outbound, now_ms and
// random_draw and raise start; it is taken at a clock edge where busy is low.
// Results appear as beats on out_tag, out_outbound, emit_kind and
// last_of_run, marked by out_strobe for exactly one cycle; the receiver
// cannot stall them. The user writes registers through cfg_write, cfg_index
// and cfg_data only while the block is idle; the block does not enforce it.
// Flow per item:
//   arrival passed through or rejected as full: strobe in the cycle after
//   acceptance, busy stays low, so a new item can follow at once
//   arrival stored: span, multiply, offset and store write states in turn
//   tick: each released packet is chosen by a linear scan of the store
//   through one read port and one shared comparator, then decide and move
//   steps; a tick with nothing due gives no beat
// Each released beat is held until the next decide, or until the store drains,
// so that the last beat of a tick can carry last_of_run.
// Reset empties the store and restores register defaults (jitter off, both
// directions selected, delay range zero); no clearing pass is needed.
`default_nettype none

module packet_jitter_delay_queue #(
    parameter int QUEUE_DEPTH = 64,
    parameter int TAG_BITS    = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              action,
    input  logic [jdq_pkg::PORT_TAG_W-1:0]    packet_tag,
    input  logic                              is_outbound,
    input  logic [jdq_pkg::TIME_W-1:0]        now_ms,
    input  logic [jdq_pkg::DELAY_W-1:0]       random_draw,
    input  logic                              cfg_write,
    input  logic [jdq_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [jdq_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic                              out_strobe,
    output logic [jdq_pkg::PORT_TAG_W-1:0]    out_tag,
    output logic                              out_outbound,
    output logic [1:0]                        emit_kind,
    output logic                              last_of_run
);
    import jdq_pkg::*;

    localparam int SB      = (TAG_BITS < PORT_TAG_W) ? TAG_BITS : PORT_TAG_W;
    localparam int IDX_W   = $clog2(QUEUE_DEPTH);
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int ENTRY_W = TIME_W + SEQ_W + 1 + SB;
    localparam int RT_LSB  = SEQ_W + 1 + SB;
    localparam int SEQ_LSB = 1 + SB;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SPAN,
        S_MUL,
        S_DLY,
        S_STORE,
        S_SCAN,
        S_DECIDE,
        S_MOVE
    } state_t;

    state_t state_reg;

    logic               jitter_en_reg;
    logic               inbound_en_reg;
    logic               outbound_en_reg;
    logic [DELAY_W-1:0] delay_low_reg;
    logic [DELAY_W-1:0] delay_high_reg;

    logic [CNT_W-1:0]   count_reg;
    logic [SEQ_W-1:0]   counter_reg;

    logic [SB-1:0]      in_tag_reg;
    logic               in_dir_reg;
    logic [TIME_W-1:0]  now_reg;
    logic [DELAY_W-1:0] rnd_reg;

    logic [IDX_W-1:0]   issue_idx_reg;
    logic               issue_on_reg;
    logic               cmp_valid_reg;
    logic [IDX_W-1:0]   cmp_idx_reg;

    order_key_t         best_key_reg;
    logic [SB-1:0]      best_tag_reg;
    logic               best_dir_reg;
    logic [IDX_W-1:0]   best_idx_reg;

    logic               pend_valid_reg;
    logic [SB-1:0]      pend_tag_reg;
    logic               pend_dir_reg;

    logic               out_strobe_reg;
    logic [SB-1:0]      out_tag_reg;
    logic               out_dir_reg;
    logic [1:0]         out_kind_reg;
    logic               out_last_reg;

    logic [ENTRY_W-1:0] mem [QUEUE_DEPTH];
    logic [ENTRY_W-1:0] rd_data_reg;
    logic [IDX_W-1:0]   rd_addr;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [ENTRY_W-1:0] wr_data;

    logic [DELAY_W-1:0] delay;
    logic [IDX_W-1:0]   last_idx;
    logic [CNT_W-1:0]   count_dec;
    order_key_t         cand_key;
    logic               cand_earlier;
    logic               take;
    logic               due;
    logic               accept;

    assign accept    = start && (state_reg == S_IDLE);
    assign busy      = (state_reg != S_IDLE);
    assign count_dec = count_reg - CNT_W'(1);
    assign last_idx  = count_dec[IDX_W-1:0];
    assign take      = jitter_en_reg && (is_outbound ? outbound_en_reg : inbound_en_reg);
    assign due       = !jitter_en_reg || (best_key_reg.rel_time <= now_reg);

    assign cand_key.rel_time = rd_data_reg[ENTRY_W-1:RT_LSB];
    assign cand_key.seq      = rd_data_reg[RT_LSB-1:SEQ_LSB];

    jdq_delay u_delay (
        .clk     (clk),
        .delay_a (delay_low_reg),
        .delay_b (delay_high_reg),
        .rnd     (rnd_reg),
        .delay   (delay)
    );

    jdq_order u_order (
        .cand    (cand_key),
        .best    (best_key_reg),
        .counter (counter_reg),
        .earlier (cand_earlier)
    );

    // store port selection
    always_comb
    begin
        rd_addr = (state_reg == S_SCAN) ? issue_idx_reg : last_idx;
        wr_en   = 1'b0;
        wr_addr = best_idx_reg;
        wr_data = rd_data_reg;
        if (state_reg == S_STORE)
        begin
            wr_en   = 1'b1;
            wr_addr = count_reg[IDX_W-1:0];
            wr_data = {now_reg + TIME_W'(delay), counter_reg, in_dir_reg, in_tag_reg};
        end
        else if (state_reg == S_MOVE)
        begin
            wr_en = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            jitter_en_reg   <= 1'b0;
            inbound_en_reg  <= 1'b1;
            outbound_en_reg <= 1'b1;
            delay_low_reg   <= '0;
            delay_high_reg  <= '0;
            count_reg       <= '0;
            counter_reg     <= '0;
            issue_on_reg    <= 1'b0;
            cmp_valid_reg   <= 1'b0;
            pend_valid_reg  <= 1'b0;
            out_strobe_reg  <= 1'b0;
        end
        else
        begin
            out_strobe_reg <= 1'b0;
            cmp_valid_reg  <= (state_reg == S_SCAN) && issue_on_reg;
            cmp_idx_reg    <= issue_idx_reg;

            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_JITTER_EN:   jitter_en_reg   <= cfg_data[0];
                    REG_INBOUND_EN:  inbound_en_reg  <= cfg_data[0];
                    REG_OUTBOUND_EN: outbound_en_reg <= cfg_data[0];
                    REG_DELAY_LOW:   delay_low_reg   <= cfg_data[DELAY_W-1:0];
                    REG_DELAY_HIGH:  delay_high_reg  <= cfg_data[DELAY_W-1:0];
                    default: ;
                endcase
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        in_tag_reg <= packet_tag[SB-1:0];
                        in_dir_reg <= is_outbound;
                        now_reg    <= now_ms;
                        rnd_reg    <= random_draw;
                        if (action == ACT_ARRIVAL)
                        begin
                            if (!take || (count_reg == CNT_W'(QUEUE_DEPTH)))
                            begin
                                out_strobe_reg <= 1'b1;
                                out_tag_reg    <= packet_tag[SB-1:0];
                                out_dir_reg    <= is_outbound;
                                out_kind_reg   <= take ? KIND_FULL : KIND_PASS;
                                out_last_reg   <= 1'b1;
                            end
                            else
                            begin
                                state_reg <= S_SPAN;
                            end
                        end
                        else if (count_reg != '0)
                        begin
                            issue_idx_reg <= '0;
                            issue_on_reg  <= 1'b1;
                            state_reg     <= S_SCAN;
                        end
                    end
                end
                S_SPAN:
                begin
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    state_reg <= S_DLY;
                end
                S_DLY:
                begin
                    state_reg <= S_STORE;
                end
                S_STORE:
                begin
                    count_reg   <= count_reg + CNT_W'(1);
                    counter_reg <= counter_reg + SEQ_W'(1);
                    state_reg   <= S_IDLE;
                end
                S_SCAN:
                begin
                    if (issue_on_reg)
                    begin
                        issue_idx_reg <= issue_idx_reg + IDX_W'(1);
                        if (issue_idx_reg == last_idx)
                        begin
                            issue_on_reg <= 1'b0;
                        end
                    end
                    if (cmp_valid_reg)
                    begin
                        if ((cmp_idx_reg == '0) || cand_earlier)
                        begin
                            best_key_reg <= cand_key;
                            best_tag_reg <= rd_data_reg[SB-1:0];
                            best_dir_reg <= rd_data_reg[SB];
                            best_idx_reg <= cmp_idx_reg;
                        end
                        if (cmp_idx_reg == last_idx)
                        begin
                            state_reg <= S_DECIDE;
                        end
                    end
                end
                S_DECIDE:
                begin
                    if (pend_valid_reg)
                    begin
                        out_strobe_reg <= 1'b1;
                        out_tag_reg    <= pend_tag_reg;
                        out_dir_reg    <= pend_dir_reg;
                        out_kind_reg   <= KIND_DELAYED;
                        out_last_reg   <= !due;
                    end
                    if (due)
                    begin
                        pend_valid_reg <= 1'b1;
                        pend_tag_reg   <= best_tag_reg;
                        pend_dir_reg   <= best_dir_reg;
                        state_reg      <= S_MOVE;
                    end
                    else
                    begin
                        pend_valid_reg <= 1'b0;
                        state_reg      <= S_IDLE;
                    end
                end
                S_MOVE:
                begin
                    count_reg <= count_dec;
                    if (count_dec == '0)
                    begin
                        out_strobe_reg <= 1'b1;
                        out_tag_reg    <= pend_tag_reg;
                        out_dir_reg    <= pend_dir_reg;
                        out_kind_reg   <= KIND_DELAYED;
                        out_last_reg   <= 1'b1;
                        pend_valid_reg <= 1'b0;
                        state_reg      <= S_IDLE;
                    end
                    else
                    begin
                        issue_idx_reg <= '0;
                        issue_on_reg  <= 1'b1;
                        state_reg     <= S_SCAN;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_strobe   = out_strobe_reg;
    assign out_tag      = PORT_TAG_W'(out_tag_reg);
    assign out_outbound = out_dir_reg;
    assign emit_kind    = out_kind_reg;
    assign last_of_run  = out_last_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("store fill beyond depth");

    a_store_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_STORE) |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("stored arrival did not grow the store by one");

    a_last_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_strobe |-> (last_of_run == !busy))
        else $error("last beat flag disagrees with sequencer state");

    a_full_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (out_strobe && (emit_kind == KIND_FULL)) |-> (count_reg == CNT_W'(QUEUE_DEPTH)))
        else $error("full beat while store has room");

    a_release_has_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MOVE) |-> (count_reg != '0))
        else $error("release from an empty store");

endmodule

`default_nettype wire
